@@ sv/eia_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eia_pkg
// Shared widths, operation and status codes, and memory request types for
// the entity ID allocator.
// ----------------------------------------------------------------------------
package eia_pkg;

  // Pool geometry and field widths
  localparam int POOL_N = 1024;
  localparam int ENT_W  = $clog2(POOL_N);
  localparam int CNT_W  = ENT_W + 1;
  localparam int SIG_W  = 32;
  localparam int FUNC_W = 3;
  localparam int STAT_W = 2;

  // Operation codes
  typedef enum logic [FUNC_W-1:0] {
    FN_ALLOC     = 3'd0,
    FN_FREE      = 3'd1,
    FN_QUERY     = 3'd2,
    FN_SET_MASK  = 3'd3,
    FN_OR_MASK   = 3'd4,
    FN_CLR_BITS  = 3'd5,
    FN_READ_MASK = 3'd6,
    FN_CLEAR_ALL = 3'd7
  } func_t;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK         = 2'd0,
    ST_EMPTY      = 2'd1,
    ST_NOT_ACTIVE = 2'd2
  } status_t;

  // Controller states
  typedef enum logic [1:0] {
    S_SWEEP,
    S_IDLE,
    S_EXEC
  } state_t;

  // One entry of the per-ID metadata memory
  typedef struct packed {
    logic             active;
    logic [SIG_W-1:0] mask;
  } meta_t;

  // Free ring memory request
  typedef struct packed {
    logic             rd_en;
    logic [ENT_W-1:0] rd_addr;
    logic             wr_en;
    logic [ENT_W-1:0] wr_addr;
    logic [ENT_W-1:0] wr_data;
  } ring_req_t;

  // Metadata memory request
  typedef struct packed {
    logic             rd_en;
    logic [ENT_W-1:0] rd_addr;
    logic             wr_en;
    logic [ENT_W-1:0] wr_addr;
    meta_t            wr_data;
  } meta_req_t;

endpackage

@@ sv/eia_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eia_in_if
// Request channel: one word carries an operation, an entity ID and a mask.
// ----------------------------------------------------------------------------
interface eia_in_if;
  import eia_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [ENT_W-1:0]  entity;
  logic [SIG_W-1:0]  signature;

  modport source (output valid, func, entity, signature, input ready);
  modport sink   (input valid, func, entity, signature, output ready);
endinterface

@@ sv/eia_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eia_out_if
// Result channel: one word per request with status, ID, mask and live count.
// ----------------------------------------------------------------------------
interface eia_out_if;
  import eia_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [ENT_W-1:0]  entity_out;
  logic [SIG_W-1:0]  mask_out;
  logic [CNT_W-1:0]  live_count;

  modport source (output valid, status, entity_out, mask_out, live_count, input ready);
  modport sink   (input valid, status, entity_out, mask_out, live_count, output ready);
endinterface

@@ sv/eia_free_ring.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eia_free_ring
// FIFO ring of free entity IDs: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module eia_free_ring (
  input  logic                    clk,
  input  eia_pkg::ring_req_t      req,
  output logic [eia_pkg::ENT_W-1:0] rd_data_r
);
  import eia_pkg::*;

  logic [ENT_W-1:0] mem [POOL_N];

  // Write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // Read port, registered; data holds while not enabled
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

endmodule

@@ sv/eia_meta_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eia_meta_store
// Per-ID metadata memory: active flag and signature mask in one entry.
// ----------------------------------------------------------------------------
module eia_meta_store (
  input  logic               clk,
  input  eia_pkg::meta_req_t req,
  output eia_pkg::meta_t     rd_data_r
);
  import eia_pkg::*;

  meta_t mem [POOL_N];

  // Write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // Read port, registered; data holds while not enabled
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

endmodule

@@ sv/entity_id_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// entity_id_allocator
// Hands out entity IDs from a FIFO free ring and keeps a signature mask and
// active flag per ID, with read-modify-write over two synchronous memories.
// ----------------------------------------------------------------------------
// A request word is accepted in idle, which launches both memory reads; the
//   execute step then modifies, writes back to the ring and metadata memories
//   and loads the result register, waiting while it is full. No new request is taken until execute is done.
// Reset and clear all run a clearing pass (ring refilled with 0..1023, all
//   masks and active flags zeroed); no request is taken then.
// The result of clear all is issued before its clearing pass starts.
module entity_id_allocator (
  input  logic      clk,
  input  logic      rst_n,
  eia_in_if.sink    in_ch,
  eia_out_if.source out_ch
);
  import eia_pkg::*;

  state_t state_r, state_nxt;

  logic [ENT_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] free_cnt_r, free_cnt_nxt;
  logic [CNT_W-1:0] total_r, total_nxt;
  logic [ENT_W-1:0] sweep_r, sweep_nxt;

  // Captured request
  logic [FUNC_W-1:0] func_r;
  logic [ENT_W-1:0]  ent_r;
  logic [SIG_W-1:0]  sig_r;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  logic              out_load;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic [ENT_W-1:0]  eout_r, eout_nxt;
  logic [SIG_W-1:0]  mout_r, mout_nxt;
  logic [CNT_W-1:0]  live_r;

  ring_req_t        ring_req;
  meta_req_t        meta_req;
  logic [ENT_W-1:0] ring_rd;
  meta_t            meta_rd;

  logic             accept;
  logic             out_free;
  logic [SIG_W-1:0] new_mask;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // Memories
  eia_free_ring u_ring (
    .clk       (clk),
    .req       (ring_req),
    .rd_data_r (ring_rd)
  );

  eia_meta_store u_meta (
    .clk       (clk),
    .req       (meta_req),
    .rd_data_r (meta_rd)
  );

  // Mask update for set / OR / clear-bits
  always_comb begin
    case (func_t'(func_r))
      FN_SET_MASK: new_mask = sig_r;
      FN_OR_MASK:  new_mask = meta_rd.mask | sig_r;
      default:     new_mask = meta_rd.mask & ~sig_r;
    endcase
  end

  // Next state, memory requests and result
  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    free_cnt_nxt = free_cnt_r;
    total_nxt    = total_r;
    sweep_nxt    = sweep_r;
    out_load     = 1'b0;
    status_nxt   = ST_OK;
    eout_nxt     = ent_r;
    mout_nxt     = meta_rd.mask;
    in_ch.ready  = 1'b0;

    ring_req         = '0;
    ring_req.rd_addr = head_r;
    meta_req         = '0;
    meta_req.rd_addr = in_ch.entity;

    unique case (state_r)
      // Clearing pass: one ring and one metadata entry per cycle
      S_SWEEP: begin
        ring_req.wr_en   = 1'b1;
        ring_req.wr_addr = sweep_r;
        ring_req.wr_data = sweep_r;
        meta_req.wr_en   = 1'b1;
        meta_req.wr_addr = sweep_r;
        meta_req.wr_data = '0;
        sweep_nxt        = sweep_r + 1'b1;
        if (sweep_r == ENT_W'(POOL_N - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      // Take a request word and launch both memory reads
      S_IDLE: begin
        in_ch.ready    = 1'b1;
        ring_req.rd_en = accept;
        meta_req.rd_en = accept;
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end

      // Modify and write back; waits while the output register is full
      S_EXEC: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
          unique case (func_t'(func_r))
            FN_ALLOC: begin
              mout_nxt = '0;
              if (free_cnt_r == '0) begin
                status_nxt = ST_EMPTY;
                eout_nxt   = '0;
              end else begin
                eout_nxt         = ring_rd;
                meta_req.wr_en   = 1'b1;
                meta_req.wr_addr = ring_rd;
                meta_req.wr_data = '{active: 1'b1, mask: '0};
                head_nxt         = head_r + 1'b1;
                free_cnt_nxt     = free_cnt_r - 1'b1;
                total_nxt        = total_r + 1'b1;
              end
            end
            FN_FREE: begin
              if (meta_rd.active) begin
                ring_req.wr_en   = 1'b1;
                ring_req.wr_addr = head_r + free_cnt_r[ENT_W-1:0];
                ring_req.wr_data = ent_r;
                meta_req.wr_en   = 1'b1;
                meta_req.wr_addr = ent_r;
                meta_req.wr_data = '0;
                free_cnt_nxt     = free_cnt_r + 1'b1;
                total_nxt        = total_r - 1'b1;
                mout_nxt         = '0;
              end
            end
            FN_QUERY: begin
              status_nxt = meta_rd.active ? ST_OK : ST_NOT_ACTIVE;
            end
            FN_SET_MASK, FN_OR_MASK, FN_CLR_BITS: begin
              if (!meta_rd.active) begin
                status_nxt = ST_NOT_ACTIVE;
              end else begin
                meta_req.wr_en   = 1'b1;
                meta_req.wr_addr = ent_r;
                meta_req.wr_data = '{active: 1'b1, mask: new_mask};
                mout_nxt         = new_mask;
              end
            end
            FN_READ_MASK: begin
            end
            FN_CLEAR_ALL: begin
              mout_nxt     = '0;
              head_nxt     = '0;
              free_cnt_nxt = CNT_W'(POOL_N);
              total_nxt    = '0;
              sweep_nxt    = '0;
              state_nxt    = S_SWEEP;
            end
            default: begin
            end
          endcase
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output word handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      head_r      <= '0;
      free_cnt_r  <= CNT_W'(POOL_N);
      total_r     <= '0;
      sweep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      free_cnt_r  <= free_cnt_nxt;
      total_r     <= total_nxt;
      sweep_r     <= sweep_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= in_ch.func;
      ent_r  <= in_ch.entity;
      sig_r  <= in_ch.signature;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      status_r <= status_nxt;
      eout_r   <= eout_nxt;
      mout_r   <= mout_nxt;
      live_r   <= total_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = status_r;
  assign out_ch.entity_out = eout_r;
  assign out_ch.mask_out   = mout_r;
  assign out_ch.live_count = live_r;

  // Free and active counts always cover the whole pool
  a_count_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (free_cnt_r + total_r) == CNT_W'(POOL_N))
    else $error("free count plus active count differs from pool size");

  // An accepted word always goes to the modify/write-back cycle
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_EXEC))
    else $error("accepted word did not enter execute");

  // A result word only appears out of the execute cycle
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EXEC))
    else $error("result word raised outside execute");

  // No memory write is lost to a stalled output: writes only when loading
  a_write_gated: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && (ring_req.wr_en || meta_req.wr_en)) |-> out_load)
    else $error("write-back while result register is full");

endmodule
